[hw/rtl/ioa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioa_pkg
// Shared types and constants for the insertable ordered array.
// ----------------------------------------------------------------------------
package ioa_pkg;

    localparam int FUNC_W   = 3;
    localparam int POS_W    = 4;
    localparam int KEY_IO_W = 32;
    localparam int COUNT_W  = 5;
    localparam int CAP_W    = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND    = 3'd0,
        FUNC_INSERT    = 3'd1,
        FUNC_READ      = 3'd2,
        FUNC_REMOVE    = 3'd3,
        FUNC_OVERWRITE = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_REMOVE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     at;
        logic     above;
    } t_cell_ctl;

endpackage

[hw/rtl/insertable_ordered_array.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertable_ordered_array
// Ordered key array with append, insert, read, remove and overwrite by index.
// ----------------------------------------------------------------------------
// channel | direction | handshake                 | payload
// in      | input     | i_in_valid / o_in_stall   | i_func, i_position, i_key_value
// out     | output    | o_out_valid / i_out_stall | o_read_value, o_count, o_status
// cfg     | input     | i_cfg_wr_en               | i_cfg_wr_data
//
// every cell shifts or loads in parallel at the transfer
// the result is registered and shows in the cycle after the input transfer
// an item is taken while the result register is empty or being drained
// synchronous active-low reset empties the array and sets capacity to 16
// ----------------------------------------------------------------------------
module insertable_ordered_array #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ioa_pkg::FUNC_W-1:0]     i_func,
    input  logic [ioa_pkg::POS_W-1:0]      i_position,
    input  logic [ioa_pkg::KEY_IO_W-1:0]   i_key_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ioa_pkg::KEY_IO_W-1:0]   o_read_value,
    output logic [ioa_pkg::COUNT_W-1:0]    o_count,
    output logic [1:0]                     o_status,
    input  logic                           i_cfg_wr_en,
    input  logic [ioa_pkg::CAP_W-1:0]      i_cfg_wr_data
);
    import ioa_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CNT_W-1:0]     r_fill;
    logic [CNT_W-1:0]     n_fill;
    logic [CAP_W-1:0]     r_cap;
    logic                 r_out_valid;
    logic [KEY_IO_W-1:0]  r_read_value;
    logic [COUNT_W-1:0]   r_count;
    t_status              r_status;

    logic                 w_accept;
    logic [CMP_W-1:0]     w_fill_ext;
    logic [CMP_W-1:0]     w_pos_ext;
    logic                 w_full;
    logic                 w_pos_bad;
    logic [IDX_W-1:0]     w_idx;
    t_cell_op             w_op;
    t_status              n_status;
    logic [KEY_IO_W-1:0]  n_read_value;
    logic [KEY_WIDTH-1:0] w_key;
    logic [KEY_WIDTH-1:0] w_cell_q [DEPTH];
    t_cell_ctl            w_ctl    [DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_fill_ext = CMP_W'(r_fill);
    assign w_pos_ext  = CMP_W'(i_position);
    assign w_full     = (w_fill_ext >= CMP_W'(r_cap)) || (w_fill_ext >= CMP_W'(DEPTH));
    assign w_pos_bad  = (w_pos_ext >= w_fill_ext);
    assign w_key      = KEY_WIDTH'(i_key_value);

    always_comb begin
        n_fill       = r_fill;
        n_status     = STATUS_OK;
        n_read_value = '0;
        w_op         = CELL_HOLD;
        w_idx        = w_pos_ext[IDX_W-1:0];
        case (i_func)
            FUNC_APPEND: begin
                w_idx = w_fill_ext[IDX_W-1:0];
                if (w_full) begin
                    n_status = STATUS_FULL;
                end else begin
                    w_op   = CELL_WRITE;
                    n_fill = r_fill + CNT_W'(1);
                end
            end
            FUNC_INSERT: begin
                if (w_pos_ext > w_fill_ext) begin
                    n_status = STATUS_RANGE;
                end else if (w_full) begin
                    n_status = STATUS_FULL;
                end else begin
                    w_op   = CELL_INSERT;
                    n_fill = r_fill + CNT_W'(1);
                end
            end
            FUNC_READ: begin
                if (w_pos_bad) begin
                    n_status = STATUS_RANGE;
                end else begin
                    n_read_value = KEY_IO_W'(w_cell_q[w_pos_ext[IDX_W-1:0]]);
                end
            end
            FUNC_REMOVE: begin
                if (w_pos_bad) begin
                    n_status = STATUS_RANGE;
                end else begin
                    w_op   = CELL_REMOVE;
                    n_fill = r_fill - CNT_W'(1);
                end
            end
            FUNC_OVERWRITE: begin
                if (w_pos_bad) begin
                    n_status = STATUS_RANGE;
                end else begin
                    w_op = CELL_WRITE;
                end
            end
            default: begin
                n_status = STATUS_OK;
            end
        endcase
        if (!w_accept) begin
            w_op = CELL_HOLD;
        end
    end

    // chain of cells, each shifting toward its neighbor
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [KEY_WIDTH-1:0] w_lower;
        logic [KEY_WIDTH-1:0] w_upper;

        assign w_ctl[gi].op    = w_op;
        assign w_ctl[gi].at    = (w_idx == IDX_W'(gi));
        assign w_ctl[gi].above = (w_idx < IDX_W'(gi));

        if (gi == 0) begin : g_first
            assign w_lower = '0;
        end else begin : g_mid_lo
            assign w_lower = w_cell_q[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign w_upper = '0;
        end else begin : g_mid_hi
            assign w_upper = w_cell_q[gi+1];
        end

        ioa_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[gi]),
            .i_key   (w_key),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_q     (w_cell_q[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_value <= n_read_value;
            r_count      <= COUNT_W'(n_fill);
            r_status     <= n_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_count      = r_count;
    assign o_status     = r_status;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_fill) <= CMP_W'(DEPTH))
        else $error("fill count above depth");

    a_count_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_count == COUNT_W'(r_fill)))
        else $error("result count differs from fill count");

    a_fail_keeps_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (n_status != STATUS_OK)) |=> (r_fill == $past(r_fill)))
        else $error("failed operation changed fill count");

    a_read_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != STATUS_OK)) |-> (r_read_value == '0))
        else $error("nonzero read value on failed operation");
`endif

endmodule

[hw/rtl/ioa_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioa_cell
// One entry of the array: holds, loads the key, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module ioa_cell #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                  i_clk,
    input  ioa_pkg::t_cell_ctl    i_ctl,
    input  logic [KEY_WIDTH-1:0]  i_key,
    input  logic [KEY_WIDTH-1:0]  i_lower,
    input  logic [KEY_WIDTH-1:0]  i_upper,
    output logic [KEY_WIDTH-1:0]  o_q
);
    import ioa_pkg::*;

    logic [KEY_WIDTH-1:0] r_q;
    logic [KEY_WIDTH-1:0] n_q;

    always_comb begin
        n_q = r_q;
        case (i_ctl.op)
            CELL_WRITE: begin
                if (i_ctl.at) begin
                    n_q = i_key;
                end
            end
            CELL_INSERT: begin
                if (i_ctl.at) begin
                    n_q = i_key;
                end else if (i_ctl.above) begin
                    n_q = i_lower;
                end
            end
            CELL_REMOVE: begin
                if (i_ctl.at || i_ctl.above) begin
                    n_q = i_upper;
                end
            end
            default: begin
                n_q = r_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule
